/* sv/assert_macros.svh */
// Assertion macros used by the sorted priority queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/spq_pkg.sv */
// Types and codes shared by the sorted priority queue modules.
package spq_pkg;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;
  localparam int OCC_W  = 7;
  localparam int STAT_W = 2;

  // Operation codes on the func field
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

/* sv/spq_cell.sv */
// One cell of the queue chain: holds a single entry and shifts with its neighbours.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_ent,
  input  spq_pkg::entry_t    left_ent,
  input  spq_pkg::entry_t    right_ent,
  input  logic               left_gt,
  input  logic               occ,
  output spq_pkg::entry_t    ent,
  output logic               gt
);

  // Empty cells count as larger, so the chain reads 0..0 1..1 along its length
  assign gt = ~occ | (ent.prio > new_ent.prio);

  // Insert: first larger cell takes the new entry, those after it shift right.
  // Cells ahead of the insert point keep their entry.
  // Remove: every cell takes its right neighbour.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (gt && !left_gt) begin
        ent <= new_ent;
      end else if (left_gt) begin
        ent <= left_ent;
      end
    end else if (ctl.rem) begin
      ent <= right_ent;
    end
  end

endmodule

/* sv/sorted_priority_queue.sv */
// Top level of the sorted priority queue: cell chain, count and result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------------
//  input   | in_valid  | in_stall  | func, prio, tag
//  result  | res_valid | res_stall | status, out_valid, out_prio, out_tag, occupancy
//
// One item per clock while in_stall is low: all cells compare against the new priority at once and
// shift in the same edge, at which the result is also loaded into the output register.
// rst clears the count and the result valid flag only; cell contents are not cleared.
// in_stall is high while a result is held and res_stall is high.
module sorted_priority_queue #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [spq_pkg::PRIO_W-1:0]       prio,
  input  logic [spq_pkg::TAG_W-1:0]        tag,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [spq_pkg::STAT_W-1:0]       status,
  output logic                             out_valid,
  output logic [spq_pkg::PRIO_W-1:0]       out_prio,
  output logic [spq_pkg::TAG_W-1:0]        out_tag,
  output logic [spq_pkg::OCC_W-1:0]        occupancy
);

`include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  logic               full;
  logic               empty;
  logic               do_enq;
  logic               do_deq;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    new_ent;
  spq_pkg::entry_t    ents [DEPTH];
  logic [DEPTH-1:0]   gts;
  logic [CW+spq_pkg::OCC_W-1:0] count_ext;

  // Handshake
  assign in_stall = res_valid & res_stall;
  assign accept   = in_valid & ~in_stall;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_enq = accept && (func == spq_pkg::FUNC_ENQ) && !full;
  assign do_deq = accept && (func == spq_pkg::FUNC_DEQ) && !empty;

  assign ctl.ins      = do_enq;
  assign ctl.rem      = do_deq;
  assign new_ent.prio = prio;
  assign new_ent.tag  = tag;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            left_gt;
    logic            occ;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign left_ent = new_ent;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = ents[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .left_gt   (left_gt),
      .occ       (occ),
      .ent       (ents[i]),
      .gt        (gts[i])
    );
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + CW'(1);
    end else if (do_deq) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign count_ext = {{spq_pkg::OCC_W{1'b0}}, count_next};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      occupancy <= count_ext[spq_pkg::OCC_W-1:0];
      out_valid <= do_deq;
      out_prio  <= do_deq ? ents[0].prio : '0;
      out_tag   <= do_deq ? ents[0].tag : '0;
      if (func == spq_pkg::FUNC_ENQ) begin
        status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end else begin
        status <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      end
    end
  end

  // Checks
  `SPQ_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(DEPTH), "entry count beyond depth")
  `SPQ_ASSERT_NEXT(a_full_holds, accept && (func == spq_pkg::FUNC_ENQ) && full,
    (count == $past(count)) && (status == spq_pkg::ST_FULL), "full enqueue altered state")
  `SPQ_ASSERT_NEXT(a_deq_returns, do_deq,
    out_valid && (out_prio == $past(ents[0].prio)) && (count == $past(count) - CW'(1)),
    "dequeue did not return head")
  `SPQ_ASSERT_NOW(a_status_valid, res_valid && out_valid,
    status == spq_pkg::ST_OK, "returned entry with error status")

endmodule

/* bench/spq_result_checker.sv */
// Result checker for the sorted priority queue: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module spq_result_checker #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       func,
  input  logic [spq_pkg::PRIO_W-1:0] prio,
  input  logic [spq_pkg::TAG_W-1:0]  tag,
  input  logic                       res_valid,
  input  logic                       res_stall,
  input  logic [spq_pkg::STAT_W-1:0] status,
  input  logic                       out_valid,
  input  logic [spq_pkg::PRIO_W-1:0] out_prio,
  input  logic [spq_pkg::TAG_W-1:0]  out_tag,
  input  logic [spq_pkg::OCC_W-1:0]  occupancy,
  output int                         fail_count,
  output int                         outstanding,
  output int                         full_seen,
  output int                         empty_seen,
  output int                         peak_occ
);

  // What one item is predicted to return
  typedef struct packed {
    logic [spq_pkg::STAT_W-1:0] status;
    logic                       taken;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::TAG_W-1:0]  tag;
    logic [spq_pkg::OCC_W-1:0]  occ;
  } outcome_t;

  // Shadow copy of the sorted store, head at index 0
  spq_pkg::entry_t shadow [DEPTH];
  int unsigned     shadow_count;
  outcome_t        outcome_q [$];

  int errors;
  int fulls;
  int empties;
  int peak;

  // Insert after all entries of lower or equal priority, or pop the head
  function automatic outcome_t queue_op(logic op, logic [spq_pkg::PRIO_W-1:0] p,
                                        logic [spq_pkg::TAG_W-1:0] t);
    outcome_t    r;
    int unsigned pos;
    int unsigned k;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (op == spq_pkg::FUNC_ENQ) begin
      if (shadow_count >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow[pos].prio <= p) pos++;
        for (k = shadow_count; k > pos; k--) shadow[k] = shadow[k-1];
        shadow[pos].prio = p;
        shadow[pos].tag  = t;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.taken = 1'b1;
      r.prio  = shadow[0].prio;
      r.tag   = shadow[0].tag;
      for (k = 1; k < shadow_count; k++) shadow[k-1] = shadow[k];
      shadow_count--;
    end
    r.occ = spq_pkg::OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic int field_diff(string label, int want, int got);
    if (want == got) return 0;
    $display("%0d ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    return 1;
  endfunction

  // Results are checked before new items are predicted, as each result is registered after its item is taken
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      shadow_count = 0;
      outcome_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0d ns: unexpected result, expected none, actual status %0h occupancy %0d",
                   $time, status, occupancy);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          errors += field_diff("status", int'(want.status), int'(status));
          errors += field_diff("out_valid", int'(want.taken), int'(out_valid));
          errors += field_diff("out_prio", int'(want.prio), int'(out_prio));
          errors += field_diff("out_tag", int'(want.tag), int'(out_tag));
          errors += field_diff("occupancy", int'(want.occ), int'(occupancy));
        end
      end
      if (in_valid && !in_stall) begin
        want = queue_op(func, prio, tag);
        if (want.status == spq_pkg::ST_FULL) fulls++;
        if (want.status == spq_pkg::ST_EMPTY) empties++;
        if (int'(want.occ) > peak) peak = int'(want.occ);
        outcome_q.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= outcome_q.size();
    full_seen   <= fulls;
    empty_seen  <= empties;
    peak_occ    <= peak;
  end

endmodule

/* bench/sorted_priority_queue_tb.sv */
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

  localparam int HOLD_CYCLES = 300;

  typedef enum {PH_DIRECT, PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_FILL} phase_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       func = spq_pkg::FUNC_ENQ;
  logic [spq_pkg::PRIO_W-1:0] prio = '0;
  logic [spq_pkg::TAG_W-1:0]  tag = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [spq_pkg::STAT_W-1:0] status;
  logic                       out_valid;
  logic [spq_pkg::PRIO_W-1:0] out_prio;
  logic [spq_pkg::TAG_W-1:0]  out_tag;
  logic [spq_pkg::OCC_W-1:0]  occupancy;

  int fail_count;
  int outstanding;
  int full_seen;
  int empty_seen;
  int peak_occ;

  phase_t      phase = PH_DIRECT;
  int unsigned send_idle_pct = 0;
  int          hold_count = 0;
  int          items_sent = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  sorted_priority_queue DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .prio(prio), .tag(tag),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .out_valid(out_valid), .out_prio(out_prio),
    .out_tag(out_tag), .occupancy(occupancy)
  );

  spq_result_checker result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .prio(prio), .tag(tag),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .out_valid(out_valid), .out_prio(out_prio),
    .out_tag(out_tag), .occupancy(occupancy),
    .fail_count(fail_count), .outstanding(outstanding),
    .full_seen(full_seen), .empty_seen(empty_seen), .peak_occ(peak_occ)
  );

  function automatic int unsigned recv_stall_pct(phase_t ph);
    case (ph)
      PH_RECV_STALL: return 75;
      PH_BOTH:       return 38;
      default:       return 0;
    endcase
  endfunction

  // Receiver: one long hold-off in the fill phase, random stalls in the receiver-stall and mixed phases
  always @(posedge clk) begin
    if (phase == PH_FILL && hold_count < HOLD_CYCLES) begin
      res_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct(phase));
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(logic f, logic [spq_pkg::PRIO_W-1:0] p,
                           logic [spq_pkg::TAG_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    prio     <= p;
    tag      <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Priorities lean on the extremes and a narrow band so that ties are common
  function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return spq_pkg::PRIO_W'($urandom_range(3));
      default: return spq_pkg::PRIO_W'($urandom);
    endcase
  endfunction

  // Bursts that lean towards enqueue or dequeue so the store swings full and empty
  task automatic random_items(int n);
    int unsigned bias;
    int          len;
    while (n > 0) begin
      case ($urandom_range(2))
        0:       bias = 90;
        1:       bias = 50;
        default: bias = 12;
      endcase
      len = $urandom_range(16, 48);
      while (len > 0 && n > 0) begin
        send_item(($urandom_range(99) < bias) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ,
                  pick_prio(), spq_pkg::TAG_W'($urandom));
        len--;
        n--;
      end
    end
  endtask

  task automatic run_phase(phase_t ph, int n);
    phase <= ph;
    case (ph)
      PH_SEND_IDLE: send_idle_pct = 75;
      PH_BOTH:      send_idle_pct = 38;
      default:      send_idle_pct = 0;
    endcase
    random_items(n);
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pop, extremes, ties in arrival order, drain to empty again
    send_item(spq_pkg::FUNC_DEQ, 8'h00, 16'h0000);
    send_item(spq_pkg::FUNC_ENQ, 8'hFF, 16'hFFFF);
    send_item(spq_pkg::FUNC_ENQ, 8'h00, 16'h0000);
    send_item(spq_pkg::FUNC_ENQ, 8'h80, 16'h8000);
    send_item(spq_pkg::FUNC_ENQ, 8'h55, 16'h0001);
    send_item(spq_pkg::FUNC_ENQ, 8'h55, 16'h0002);
    send_item(spq_pkg::FUNC_ENQ, 8'h55, 16'h0003);
    send_item(spq_pkg::FUNC_ENQ, 8'h00, 16'hFFFF);
    send_item(spq_pkg::FUNC_ENQ, 8'hFF, 16'h0001);
    for (i = 0; i < 9; i++) send_item(spq_pkg::FUNC_DEQ, 8'hAA, 16'h5555);

    // Fill past capacity, then drain past empty
    phase <= PH_FREE;
    for (i = 0; i < 70; i++) begin
      send_item(spq_pkg::FUNC_ENQ, pick_prio(), spq_pkg::TAG_W'($urandom));
    end
    for (i = 0; i < 70; i++) begin
      send_item(spq_pkg::FUNC_DEQ, pick_prio(), spq_pkg::TAG_W'($urandom));
    end

    run_phase(PH_FREE, 200);
    run_phase(PH_SEND_IDLE, 200);
    run_phase(PH_RECV_STALL, 200);
    run_phase(PH_BOTH, 200);
    run_phase(PH_FILL, 100);
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d items over unthrottled, sender-idle, receiver-stall, mixed",
             items_sent);
    $display("and long hold-off traffic; %0d full and %0d empty statuses, peak occupancy %0d.",
             full_seen, empty_seen, peak_occ);
    if (fail_count == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

endmodule
